[hw/rtl/dna_read_overlap_mismatch_assert.svh]
// ---------------------------------------------------------------------------
// dna_read_overlap_mismatch_assert.svh
// Assertion macros shared by the overlap checker RTL.
// ---------------------------------------------------------------------------
`ifndef DNA_READ_OVERLAP_MISMATCH_ASSERT_SVH
`define DNA_READ_OVERLAP_MISMATCH_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define DRO_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked during reset.
`define DRO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/dro_pkg.sv]
// ---------------------------------------------------------------------------
// dro_pkg
// Types and constants shared by the read overlap checker.
// ---------------------------------------------------------------------------
package dro_pkg;

   localparam int MAX_READ_LEN = 4096;
   localparam int ADDR_W       = $clog2(MAX_READ_LEN);
   localparam int LEN_W        = ADDR_W + 1;
   localparam int IDX_W        = 24;
   localparam int POS_W        = 12;
   localparam int CFG_W        = 12;
   localparam int BASE_W       = 2;
   localparam int CMD_W        = 2;
   localparam int ORIENT_W     = 2;
   localparam int NUM_ORIENT   = 4;
   localparam int CSR_IDX_W    = 1;

   localparam logic [CFG_W-1:0] OVERLAP_RESET = CFG_W'(50);
   localparam logic [CFG_W-1:0] LIMIT_RESET   = CFG_W'(2);

   localparam logic [CSR_IDX_W-1:0] CSR_OVERLAP_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISMATCH_LIMIT = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_APPEND1 = 2'd1,
      CMD_APPEND2 = 2'd2,
      CMD_COMPARE = 2'd3
   } cmd_type;

   localparam logic [ORIENT_W-1:0] ORIENT_FWD_FWD = 2'd0;
   localparam logic [ORIENT_W-1:0] ORIENT_FWD_RC  = 2'd1;
   localparam logic [ORIENT_W-1:0] ORIENT_REV_REV = 2'd2;
   localparam logic [ORIENT_W-1:0] ORIENT_REV_RC  = 2'd3;

   typedef struct packed {
      logic                load;
      logic                step;
      logic [ORIENT_W-1:0] orient;
   } scan_ctrl_type;

endpackage

[hw/rtl/dro_read_store.sv]
// ---------------------------------------------------------------------------
// dro_read_store
// Base memory for one read with its fill length and a registered read port.
// ---------------------------------------------------------------------------
module dro_read_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          wr_en,
   input  logic [dro_pkg::BASE_W-1:0]    wr_base,
   input  logic                          rd_en,
   input  logic [dro_pkg::ADDR_W-1:0]    rd_addr,
   output logic [dro_pkg::BASE_W-1:0]    rd_base,
   output logic [dro_pkg::LEN_W-1:0]     length
);

   logic [dro_pkg::BASE_W-1:0] mem [dro_pkg::MAX_READ_LEN];
   logic [dro_pkg::LEN_W-1:0]  length_ff;
   logic [dro_pkg::LEN_W-1:0]  length_in;
   logic [dro_pkg::BASE_W-1:0] rd_base_ff;
   logic                       full;

   assign full = (length_ff == dro_pkg::LEN_W'(dro_pkg::MAX_READ_LEN));

   always_comb begin
      length_in = length_ff;
      if (clear) begin
         length_in = '0;
      end else if (wr_en && !full) begin
         length_in = length_ff + dro_pkg::LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else begin
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && !full) begin
         mem[length_ff[dro_pkg::ADDR_W-1:0]] <= wr_base;
      end
      if (rd_en) begin
         rd_base_ff <= mem[rd_addr];
      end
   end

   assign rd_base = rd_base_ff;
   assign length  = length_ff;

endmodule

[hw/rtl/dro_scan.sv]
// ---------------------------------------------------------------------------
// dro_scan
// Walks both reads one base per cycle while ctrl.step is high, for one
// orientation, and counts mismatching bases.
// ---------------------------------------------------------------------------
`include "dna_read_overlap_mismatch_assert.svh"

module dro_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  dro_pkg::scan_ctrl_type        ctrl,
   input  logic [dro_pkg::LEN_W-1:0]     n1,
   input  logic [dro_pkg::LEN_W-1:0]     n2,
   input  logic [dro_pkg::CFG_W-1:0]     len,
   input  logic [dro_pkg::BASE_W-1:0]    rd_base1,
   input  logic [dro_pkg::BASE_W-1:0]    rd_base2,
   output logic [dro_pkg::ADDR_W-1:0]    addr1,
   output logic [dro_pkg::ADDR_W-1:0]    addr2,
   output logic [dro_pkg::CFG_W-1:0]     mismatch_count
);

   logic [dro_pkg::ADDR_W-1:0] addr1_ff, addr1_in;
   logic [dro_pkg::ADDR_W-1:0] addr2_ff, addr2_in;
   logic                       down1_ff, down1_in;
   logic                       down2_ff, down2_in;
   logic                       comp_ff, comp_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [dro_pkg::CFG_W-1:0]  count_ff, count_in;
   logic [dro_pkg::ADDR_W-1:0] n1_m_len;
   logic [dro_pkg::ADDR_W-1:0] n2_m_1;
   logic [dro_pkg::ADDR_W-1:0] len_m_1;
   logic [dro_pkg::BASE_W-1:0] base2_cmp;

   // start points are taken mod read capacity
   assign n1_m_len = n1[dro_pkg::ADDR_W-1:0] - dro_pkg::ADDR_W'(len);
   assign n2_m_1   = n2[dro_pkg::ADDR_W-1:0] - dro_pkg::ADDR_W'(1);
   assign len_m_1  = dro_pkg::ADDR_W'(len) - dro_pkg::ADDR_W'(1);

   // complement of a 2-bit base code is 3 - b, i.e. bitwise invert
   assign base2_cmp = comp_ff ? ~rd_base2 : rd_base2;

   always_comb begin
      addr1_in  = addr1_ff;
      addr2_in  = addr2_ff;
      down1_in  = down1_ff;
      down2_in  = down2_ff;
      comp_in   = comp_ff;
      rd_vld_in = 1'b0;
      count_in  = count_ff;
      if (rd_vld_ff && (rd_base1 != base2_cmp)) begin
         count_in = count_ff + dro_pkg::CFG_W'(1);
      end
      if (ctrl.load) begin
         count_in = '0;
         case (ctrl.orient)
            dro_pkg::ORIENT_FWD_FWD: begin
               addr1_in = n1_m_len; addr2_in = '0;
               down1_in = 1'b0;     down2_in = 1'b0; comp_in = 1'b0;
            end
            dro_pkg::ORIENT_FWD_RC: begin
               addr1_in = n1_m_len; addr2_in = n2_m_1;
               down1_in = 1'b0;     down2_in = 1'b1; comp_in = 1'b1;
            end
            dro_pkg::ORIENT_REV_REV: begin
               addr1_in = len_m_1;  addr2_in = n2_m_1;
               down1_in = 1'b1;     down2_in = 1'b1; comp_in = 1'b0;
            end
            default: begin
               addr1_in = '0;       addr2_in = len_m_1;
               down1_in = 1'b0;     down2_in = 1'b1; comp_in = 1'b1;
            end
         endcase
      end else if (ctrl.step) begin
         rd_vld_in = 1'b1;
         addr1_in  = down1_ff ? addr1_ff - dro_pkg::ADDR_W'(1)
                              : addr1_ff + dro_pkg::ADDR_W'(1);
         addr2_in  = down2_ff ? addr2_ff - dro_pkg::ADDR_W'(1)
                              : addr2_ff + dro_pkg::ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
         count_ff  <= '0;
         down1_ff  <= 1'b0;
         down2_ff  <= 1'b0;
         comp_ff   <= 1'b0;
      end else begin
         rd_vld_ff <= rd_vld_in;
         count_ff  <= count_in;
         down1_ff  <= down1_in;
         down2_ff  <= down2_in;
         comp_ff   <= comp_in;
      end
   end

   always_ff @(posedge clock) begin
      addr1_ff <= addr1_in;
      addr2_ff <= addr2_in;
   end

   assign addr1          = addr1_ff;
   assign addr2          = addr2_ff;
   assign mismatch_count = count_ff;

   `DRO_ASSERT_NEXT(a_load_clears_count, clock, reset, ctrl.load, count_ff == '0, "count not cleared on load")
   `DRO_ASSERT_IMPL(a_vld_after_step, clock, reset, rd_vld_ff, $past(ctrl.step), "read data valid without a step")
   `DRO_ASSERT_IMPL(a_load_no_step, clock, reset, ctrl.load, !ctrl.step, "load and step together")

endmodule

[hw/rtl/dna_read_overlap_mismatch.sv]
// ---------------------------------------------------------------------------
// dna_read_overlap_mismatch
// Two-read store with a four-orientation overlap mismatch check.
// ---------------------------------------------------------------------------
// Usage:
//   Commands are taken when start is high and busy is low. Clear and the two
//   append commands leave busy low, so bases load at one per cycle while the
//   block is idle. A compare with both reads longer than overlap_length
//   raises busy and walks each of the four orientations in turn, one base
//   pair per cycle from the single read port of each store, then emits the
//   accepted records one after another.
//   Each record shows on the rsp_ ports for one cycle with rsp_valid high,
//   in the cycle after it is selected; the last one carries rsp_last_record.
//   A compare on short reads returns nothing and busy stays low; a zero
//   overlap_length skips the walk. No accepted orientation: no record, busy
//   drops after the walk. The receiver cannot stall: records are never held.
//   The csr_ channel is always ready; write it only while the block is idle.
//   Reset empties both reads and loads overlap_length = 50 and
//   mismatch_limit = 2. Base memories are not cleared.
// ---------------------------------------------------------------------------
`include "dna_read_overlap_mismatch_assert.svh"

module dna_read_overlap_mismatch (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [dro_pkg::CMD_W-1:0]       req_cmd,
   input  logic [dro_pkg::BASE_W-1:0]      req_base,
   input  logic [dro_pkg::IDX_W-1:0]       req_first_read_index,
   input  logic [dro_pkg::IDX_W-1:0]       req_second_read_index,
   output logic                            rsp_valid,
   output logic [dro_pkg::ORIENT_W-1:0]    rsp_orientation,
   output logic [dro_pkg::IDX_W-1:0]       rsp_first_index_out,
   output logic [dro_pkg::IDX_W-1:0]       rsp_second_index_out,
   output logic [dro_pkg::POS_W-1:0]       rsp_first_begin,
   output logic [dro_pkg::POS_W-1:0]       rsp_first_end,
   output logic [dro_pkg::POS_W-1:0]       rsp_second_begin,
   output logic [dro_pkg::POS_W-1:0]       rsp_second_end,
   output logic                            rsp_last_record,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dro_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dro_pkg::CFG_W-1:0]       csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_WAIT  = 5'b00100,
      ST_CHECK = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type                         state_ff, state_in;
   logic [dro_pkg::ORIENT_W-1:0]      orient_ff, orient_in;
   logic [dro_pkg::CFG_W-1:0]         remain_ff, remain_in;
   logic [dro_pkg::NUM_ORIENT-1:0]    hit_ff, hit_in;
   logic [dro_pkg::IDX_W-1:0]         id1_ff, id1_in;
   logic [dro_pkg::IDX_W-1:0]         id2_ff, id2_in;
   logic [dro_pkg::CFG_W-1:0]         overlap_length_ff, overlap_length_in;
   logic [dro_pkg::CFG_W-1:0]         mismatch_limit_ff, mismatch_limit_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [dro_pkg::ORIENT_W-1:0]      rsp_orient_ff, rsp_orient_in;
   logic [dro_pkg::IDX_W-1:0]         rsp_id1_ff, rsp_id1_in;
   logic [dro_pkg::IDX_W-1:0]         rsp_id2_ff, rsp_id2_in;
   logic [dro_pkg::POS_W-1:0]         rsp_b1_ff, rsp_b1_in;
   logic [dro_pkg::POS_W-1:0]         rsp_e1_ff, rsp_e1_in;
   logic [dro_pkg::POS_W-1:0]         rsp_b2_ff, rsp_b2_in;
   logic [dro_pkg::POS_W-1:0]         rsp_e2_ff, rsp_e2_in;
   logic                              rsp_last_ff, rsp_last_in;

   dro_pkg::scan_ctrl_type            scan_ctrl;
   dro_pkg::cmd_type                  cmd;
   logic                              accept;
   logic                              short_reads;
   logic [dro_pkg::LEN_W-1:0]         n1, n2;
   logic [dro_pkg::BASE_W-1:0]        rd_base1, rd_base2;
   logic [dro_pkg::ADDR_W-1:0]        addr1, addr2;
   logic [dro_pkg::CFG_W-1:0]         mismatch_count;
   logic                              orient_ok;
   logic [dro_pkg::NUM_ORIENT-1:0]    sel, hit_rest;
   logic [dro_pkg::ORIENT_W-1:0]      sel_orient;
   logic [dro_pkg::POS_W-1:0]         n1_m_len, n1_m_1, n2_m_len, n2_m_1, len_m_1;

   assign cmd       = dro_pkg::cmd_type'(req_cmd);
   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign short_reads = (n1 <= dro_pkg::LEN_W'(overlap_length_ff)) ||
                        (n2 <= dro_pkg::LEN_W'(overlap_length_ff));
   assign orient_ok   = (mismatch_count <= mismatch_limit_ff);

   // ----------------------------------------------------------------- stores
   dro_read_store u_store1 (
      .clock   (clock),
      .reset   (reset),
      .clear   (accept && (cmd == dro_pkg::CMD_CLEAR)),
      .wr_en   (accept && (cmd == dro_pkg::CMD_APPEND1)),
      .wr_base (req_base),
      .rd_en   (scan_ctrl.step),
      .rd_addr (addr1),
      .rd_base (rd_base1),
      .length  (n1)
   );

   dro_read_store u_store2 (
      .clock   (clock),
      .reset   (reset),
      .clear   (accept && (cmd == dro_pkg::CMD_CLEAR)),
      .wr_en   (accept && (cmd == dro_pkg::CMD_APPEND2)),
      .wr_base (req_base),
      .rd_en   (scan_ctrl.step),
      .rd_addr (addr2),
      .rd_base (rd_base2),
      .length  (n2)
   );

   dro_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (scan_ctrl),
      .n1             (n1),
      .n2             (n2),
      .len            (overlap_length_ff),
      .rd_base1       (rd_base1),
      .rd_base2       (rd_base2),
      .addr1          (addr1),
      .addr2          (addr2),
      .mismatch_count (mismatch_count)
   );

   // ------------------------------------------------------- config registers
   always_comb begin
      overlap_length_in = overlap_length_ff;
      mismatch_limit_in = mismatch_limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            dro_pkg::CSR_OVERLAP_LENGTH: overlap_length_in = csr_wdata;
            dro_pkg::CSR_MISMATCH_LIMIT: mismatch_limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------- record bounds
   assign n1_m_len = n1[dro_pkg::POS_W-1:0] - overlap_length_ff;
   assign n1_m_1   = n1[dro_pkg::POS_W-1:0] - dro_pkg::POS_W'(1);
   assign n2_m_len = n2[dro_pkg::POS_W-1:0] - overlap_length_ff;
   assign n2_m_1   = n2[dro_pkg::POS_W-1:0] - dro_pkg::POS_W'(1);
   assign len_m_1  = overlap_length_ff - dro_pkg::POS_W'(1);

   // lowest pending orientation goes out first
   assign sel      = hit_ff & (~hit_ff + dro_pkg::NUM_ORIENT'(1));
   assign hit_rest = hit_ff & ~sel;

   always_comb begin
      if (sel[1]) begin
         sel_orient = dro_pkg::ORIENT_FWD_RC;
      end else if (sel[2]) begin
         sel_orient = dro_pkg::ORIENT_REV_REV;
      end else if (sel[3]) begin
         sel_orient = dro_pkg::ORIENT_REV_RC;
      end else begin
         sel_orient = dro_pkg::ORIENT_FWD_FWD;
      end
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in         = state_ff;
      orient_in        = orient_ff;
      remain_in        = remain_ff;
      hit_in           = hit_ff;
      id1_in           = id1_ff;
      id2_in           = id2_ff;
      scan_ctrl.load   = 1'b0;
      scan_ctrl.step   = 1'b0;
      scan_ctrl.orient = orient_ff;

      rsp_valid_in  = 1'b0;
      rsp_orient_in = rsp_orient_ff;
      rsp_id1_in    = rsp_id1_ff;
      rsp_id2_in    = rsp_id2_ff;
      rsp_b1_in     = rsp_b1_ff;
      rsp_e1_in     = rsp_e1_ff;
      rsp_b2_in     = rsp_b2_ff;
      rsp_e2_in     = rsp_e2_ff;
      rsp_last_in   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (cmd == dro_pkg::CMD_COMPARE) && !short_reads) begin
               id1_in = req_first_read_index;
               id2_in = req_second_read_index;
               if (overlap_length_ff == '0) begin
                  // empty overlap: every orientation passes
                  hit_in   = '1;
                  state_in = ST_EMIT;
               end else begin
                  hit_in           = '0;
                  orient_in        = dro_pkg::ORIENT_FWD_FWD;
                  remain_in        = overlap_length_ff;
                  scan_ctrl.load   = 1'b1;
                  scan_ctrl.orient = dro_pkg::ORIENT_FWD_FWD;
                  state_in         = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            scan_ctrl.step = 1'b1;
            remain_in      = remain_ff - dro_pkg::CFG_W'(1);
            if (remain_ff == dro_pkg::CFG_W'(1)) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            // last base pair is being counted
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            hit_in = hit_ff | (dro_pkg::NUM_ORIENT'(orient_ok) << orient_ff);
            if (orient_ff == dro_pkg::ORIENT_REV_RC) begin
               state_in = (hit_in == '0) ? ST_IDLE : ST_EMIT;
            end else begin
               orient_in        = orient_ff + dro_pkg::ORIENT_W'(1);
               remain_in        = overlap_length_ff;
               scan_ctrl.load   = 1'b1;
               scan_ctrl.orient = orient_in;
               state_in         = ST_SCAN;
            end
         end
         ST_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_orient_in = sel_orient;
            rsp_id1_in    = id1_ff;
            rsp_id2_in    = id2_ff;
            if (sel_orient == dro_pkg::ORIENT_FWD_FWD ||
                sel_orient == dro_pkg::ORIENT_FWD_RC) begin
               rsp_b1_in = n1_m_len;
               rsp_e1_in = n1_m_1;
            end else begin
               rsp_b1_in = len_m_1;
               rsp_e1_in = '0;
            end
            if (sel_orient == dro_pkg::ORIENT_FWD_FWD ||
                sel_orient == dro_pkg::ORIENT_REV_RC) begin
               rsp_b2_in = '0;
               rsp_e2_in = len_m_1;
            end else begin
               rsp_b2_in = n2_m_1;
               rsp_e2_in = n2_m_len;
            end
            rsp_last_in = (hit_rest == '0);
            hit_in      = hit_rest;
            if (hit_rest == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         orient_ff         <= dro_pkg::ORIENT_FWD_FWD;
         remain_ff         <= '0;
         hit_ff            <= '0;
         overlap_length_ff <= dro_pkg::OVERLAP_RESET;
         mismatch_limit_ff <= dro_pkg::LIMIT_RESET;
         rsp_valid_ff      <= 1'b0;
         rsp_last_ff       <= 1'b0;
      end else begin
         state_ff          <= state_in;
         orient_ff         <= orient_in;
         remain_ff         <= remain_in;
         hit_ff            <= hit_in;
         overlap_length_ff <= overlap_length_in;
         mismatch_limit_ff <= mismatch_limit_in;
         rsp_valid_ff      <= rsp_valid_in;
         rsp_last_ff       <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      id1_ff        <= id1_in;
      id2_ff        <= id2_in;
      rsp_orient_ff <= rsp_orient_in;
      rsp_id1_ff    <= rsp_id1_in;
      rsp_id2_ff    <= rsp_id2_in;
      rsp_b1_ff     <= rsp_b1_in;
      rsp_e1_ff     <= rsp_e1_in;
      rsp_b2_ff     <= rsp_b2_in;
      rsp_e2_ff     <= rsp_e2_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_orientation      = rsp_orient_ff;
   assign rsp_first_index_out  = rsp_id1_ff;
   assign rsp_second_index_out = rsp_id2_ff;
   assign rsp_first_begin      = rsp_b1_ff;
   assign rsp_first_end        = rsp_e1_ff;
   assign rsp_second_begin     = rsp_b2_ff;
   assign rsp_second_end       = rsp_e2_ff;
   assign rsp_last_record      = rsp_last_ff;

   `DRO_ASSERT_NEXT(a_emit_strobes, clock, reset, state_ff == ST_EMIT, rsp_valid_ff,
      "emit cycle gave no record")
   `DRO_ASSERT_IMPL(a_last_goes_idle, clock, reset, rsp_valid_ff && rsp_last_ff,
      state_ff == ST_IDLE, "last record but still busy")
   `DRO_ASSERT_IMPL(a_emit_has_hit, clock, reset, state_ff == ST_EMIT, hit_ff != '0,
      "emit with no pending orientation")

endmodule
